@@ sv/assert_macros.svh @@
// Assertion macros shared by the mixed RLE encoder RTL.
// Included by the modules that carry concurrent assertions; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

`define ASSERT_NEVER(lbl, clk, rstn, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
    else $error(msg);

`else

`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons, msg)

`define ASSERT_NEVER(lbl, clk, rstn, expr, msg)

`endif

`endif

@@ sv/mrle_pkg.sv @@
// Package for the mixed RLE pixel encoder: sizes, header codes and the
// types passed between controller and datapath. No dependencies.
`default_nettype none

package mrle_pkg;

  localparam int MAX_LITERAL = 128;
  localparam int MAX_RUN     = 65535;
  localparam int VALUE_WIDTH = 24;

  localparam int PIX_W   = 24;
  localparam int LONG_W  = 16;
  localparam int CNT_W   = $clog2(MAX_RUN + 1);
  localparam int LIT_IDX_W = $clog2(MAX_LITERAL);
  localparam int LANES   = 4;
  localparam int LANE_W  = 2;
  localparam int ROWS    = MAX_LITERAL / LANES;
  localparam int ROW_W   = LIT_IDX_W - LANE_W;

  localparam logic [7:0] HDR_LONG = 8'd128;
  localparam logic [7:0] RUN_BIAS = 8'd127;
  localparam int SHORT_RUN_BOUND  = 128;

  typedef enum logic [1:0] {
    PKT_NONE,
    PKT_LIT,
    PKT_RUN
  } pkt_kind_e;

  typedef struct packed {
    pkt_kind_e               kind;
    logic [CNT_W-1:0]        len;
    logic [VALUE_WIDTH-1:0]  val;
  } pkt_t;

  localparam pkt_t PKT_EMPTY = '{kind: PKT_NONE, len: '0, val: '0};

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_SEND
  } ctrl_state_e;

  typedef struct packed {
    logic accept;
    logic load;
    logic next;
  } dp_cmd_t;

  typedef struct packed {
    logic has_pkt;
    logic more;
  } dp_sts_t;

endpackage

`default_nettype wire

@@ sv/mrle_datapath.sv @@
// Datapath of the mixed RLE encoder: pending count, run flag, literal
// buffer in four lanes, packet plan and result formatting. Uses mrle_pkg.
`default_nettype none
`include "assert_macros.svh"

module mrle_datapath (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  mrle_pkg::dp_cmd_t     cmd_i,
  output mrle_pkg::dp_sts_t     sts_o,
  input  logic [23:0]           pixel_value_i,
  input  logic                  end_of_line_i,
  output logic                  has_header_o,
  output logic [7:0]            header_byte_o,
  output logic                  has_long_count_o,
  output logic [15:0]           long_count_o,
  output logic [2:0]            value_count_o,
  output logic [23:0]           value_a_o,
  output logic [23:0]           value_b_o,
  output logic [23:0]           value_c_o,
  output logic [23:0]           value_d_o,
  output logic                  last_of_run_o
);

  logic [mrle_pkg::CNT_W-1:0]       cnt_q, cnt_d;
  logic                             run_q, run_d;
  logic [mrle_pkg::VALUE_WIDTH-1:0] last_q;
  logic [mrle_pkg::VALUE_WIDTH-1:0] col;
  logic                             eq;
  logic                             wr_en;
  logic [mrle_pkg::LIT_IDX_W-1:0]   wr_idx;
  mrle_pkg::pkt_t                   pa, pb;
  mrle_pkg::pkt_t                   pkt0_q, pkt1_q, cur_pkt;
  logic                             sel_q;
  logic [mrle_pkg::ROW_W-1:0]       row_q;
  logic [mrle_pkg::VALUE_WIDTH-1:0] rdata_q [mrle_pkg::LANES];
  logic [mrle_pkg::LIT_IDX_W:0]     row_off;
  logic [mrle_pkg::LIT_IDX_W:0]     rem;
  logic                             lit_last;
  logic                             last_result;
  logic [mrle_pkg::VALUE_WIDTH-1:0] vals [mrle_pkg::LANES];

  // Next state of the encoder and the packets that this beat releases.
  // The last accepted value always equals the entry a repeat is compared to.
  always_comb begin
    col    = pixel_value_i[mrle_pkg::VALUE_WIDTH-1:0];
    eq     = (col == last_q);
    cnt_d  = cnt_q;
    run_d  = run_q;
    wr_en  = 1'b0;
    wr_idx = '0;
    pa     = mrle_pkg::PKT_EMPTY;
    pb     = mrle_pkg::PKT_EMPTY;
    if (cnt_q == '0) begin
      wr_en = 1'b1;
      cnt_d = mrle_pkg::CNT_W'(1);
    end else if (cnt_q == mrle_pkg::CNT_W'(1)) begin
      run_d  = eq;
      wr_en  = !eq;
      wr_idx = mrle_pkg::LIT_IDX_W'(1);
      cnt_d  = mrle_pkg::CNT_W'(2);
    end else if (!run_q) begin
      if (eq) begin
        // A repeat ends the literal; the repeated pair opens a run.
        pa.kind = mrle_pkg::PKT_LIT;
        pa.len  = cnt_q - mrle_pkg::CNT_W'(1);
        cnt_d   = mrle_pkg::CNT_W'(2);
        run_d   = 1'b1;
      end else begin
        wr_en  = 1'b1;
        wr_idx = cnt_q[mrle_pkg::LIT_IDX_W-1:0];
        cnt_d  = cnt_q + mrle_pkg::CNT_W'(1);
        if (cnt_q == mrle_pkg::CNT_W'(mrle_pkg::MAX_LITERAL - 1)) begin
          pa.kind = mrle_pkg::PKT_LIT;
          pa.len  = mrle_pkg::CNT_W'(mrle_pkg::MAX_LITERAL);
          cnt_d   = '0;
        end
      end
    end else begin
      if (!eq) begin
        pa.kind = mrle_pkg::PKT_RUN;
        pa.len  = cnt_q;
        pa.val  = last_q;
        wr_en   = 1'b1;
        cnt_d   = mrle_pkg::CNT_W'(1);
      end else if (cnt_q == mrle_pkg::CNT_W'(mrle_pkg::MAX_RUN - 1)) begin
        pa.kind = mrle_pkg::PKT_RUN;
        pa.len  = mrle_pkg::CNT_W'(mrle_pkg::MAX_RUN);
        pa.val  = col;
        cnt_d   = '0;
      end else begin
        cnt_d = cnt_q + mrle_pkg::CNT_W'(1);
      end
    end
    if (end_of_line_i) begin
      if (cnt_d != '0) begin
        pb.len  = cnt_d;
        pb.val  = col;
        pb.kind = ((cnt_d == mrle_pkg::CNT_W'(1)) || !run_d) ? mrle_pkg::PKT_LIT
                                                            : mrle_pkg::PKT_RUN;
      end
      cnt_d = '0;
      run_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      run_q  <= 1'b0;
      pkt0_q <= mrle_pkg::PKT_EMPTY;
      pkt1_q <= mrle_pkg::PKT_EMPTY;
      sel_q  <= 1'b0;
      row_q  <= '0;
    end else if (cmd_i.accept) begin
      cnt_q <= cnt_d;
      run_q <= run_d;
      sel_q <= 1'b0;
      row_q <= '0;
      if (pa.kind != mrle_pkg::PKT_NONE) begin
        pkt0_q <= pa;
        pkt1_q <= pb;
      end else begin
        pkt0_q <= pb;
        pkt1_q <= mrle_pkg::PKT_EMPTY;
      end
    end else if (cmd_i.next) begin
      if (last_result) begin
        sel_q <= 1'b1;
        row_q <= '0;
      end else begin
        row_q <= row_q + mrle_pkg::ROW_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      last_q <= col;
    end
  end

  // Literal buffer: entry i lives in lane i mod 4, row i / 4, so one read
  // fetches all four values of a result.
  for (genvar l = 0; l < mrle_pkg::LANES; l++) begin : g_lane
    logic [mrle_pkg::VALUE_WIDTH-1:0] lane_mem [mrle_pkg::ROWS];

    always_ff @(posedge clk_i) begin
      if (cmd_i.accept && wr_en &&
          (wr_idx[mrle_pkg::LANE_W-1:0] == mrle_pkg::LANE_W'(l))) begin
        lane_mem[wr_idx[mrle_pkg::LIT_IDX_W-1:mrle_pkg::LANE_W]] <= col;
      end
    end

    always_ff @(posedge clk_i) begin
      if (cmd_i.load) begin
        rdata_q[l] <= lane_mem[row_q];
      end
    end
  end

  assign cur_pkt     = sel_q ? pkt1_q : pkt0_q;
  assign row_off     = {1'b0, row_q, {mrle_pkg::LANE_W{1'b0}}};
  assign rem         = cur_pkt.len[mrle_pkg::LIT_IDX_W:0] - row_off;
  assign lit_last    = (rem <= (mrle_pkg::LIT_IDX_W + 1)'(mrle_pkg::LANES));
  assign last_result = (cur_pkt.kind != mrle_pkg::PKT_LIT) || lit_last;

  assign sts_o.has_pkt = (pkt0_q.kind != mrle_pkg::PKT_NONE);
  assign sts_o.more    = !last_result || (!sel_q && (pkt1_q.kind != mrle_pkg::PKT_NONE));

  always_comb begin
    has_header_o     = 1'b0;
    header_byte_o    = '0;
    has_long_count_o = 1'b0;
    long_count_o     = '0;
    value_count_o    = '0;
    for (int l = 0; l < mrle_pkg::LANES; l++) begin
      vals[l] = '0;
    end
    case (cur_pkt.kind)
      mrle_pkg::PKT_LIT: begin
        has_header_o  = (row_q == '0);
        header_byte_o = has_header_o ? 8'(cur_pkt.len - mrle_pkg::CNT_W'(1)) : 8'd0;
        value_count_o = lit_last ? rem[2:0] : 3'(mrle_pkg::LANES);
        for (int l = 0; l < mrle_pkg::LANES; l++) begin
          if (3'(l) < value_count_o) begin
            vals[l] = rdata_q[l];
          end
        end
      end
      mrle_pkg::PKT_RUN: begin
        has_header_o  = 1'b1;
        value_count_o = 3'd1;
        vals[0]       = cur_pkt.val;
        if (cur_pkt.len < mrle_pkg::CNT_W'(mrle_pkg::SHORT_RUN_BOUND)) begin
          header_byte_o = cur_pkt.len[7:0] + mrle_pkg::RUN_BIAS;
        end else begin
          header_byte_o    = mrle_pkg::HDR_LONG;
          has_long_count_o = 1'b1;
          long_count_o     = mrle_pkg::LONG_W'(cur_pkt.len);
        end
      end
      default: begin
      end
    endcase
  end

  assign value_a_o     = mrle_pkg::PIX_W'(vals[0]);
  assign value_b_o     = mrle_pkg::PIX_W'(vals[1]);
  assign value_c_o     = mrle_pkg::PIX_W'(vals[2]);
  assign value_d_o     = mrle_pkg::PIX_W'(vals[3]);
  assign last_of_run_o = !sts_o.more;

  `ASSERT_IMPLIES(a_lit_cnt_bound, clk_i, rst_ni, !run_q, cnt_q < mrle_pkg::CNT_W'(mrle_pkg::MAX_LITERAL), "literal count reached the buffer size")
  `ASSERT_IMPLIES(a_pkt_order, clk_i, rst_ni, pkt1_q.kind != mrle_pkg::PKT_NONE, pkt0_q.kind != mrle_pkg::PKT_NONE, "second packet planned without a first")
  `ASSERT_IMPLIES(a_row_in_pkt, clk_i, rst_ni, cur_pkt.kind == mrle_pkg::PKT_LIT, mrle_pkg::CNT_W'(row_off) < cur_pkt.len, "literal row beyond packet length")

endmodule

`default_nettype wire

@@ sv/mrle_ctrl.sv @@
// Controller of the mixed RLE encoder: takes one beat, then steps the
// datapath through a read and a send state per result. Uses mrle_pkg.
`default_nettype none
`include "assert_macros.svh"

module mrle_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output mrle_pkg::dp_cmd_t  cmd_o,
  input  mrle_pkg::dp_sts_t  sts_i
);

  mrle_pkg::ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mrle_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      mrle_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = mrle_pkg::ST_LOAD;
        end
      end
      mrle_pkg::ST_LOAD: begin
        // An item that releases no packet goes straight back to idle.
        state_d = sts_i.has_pkt ? mrle_pkg::ST_SEND : mrle_pkg::ST_IDLE;
      end
      mrle_pkg::ST_SEND: begin
        if (out_ready_i) begin
          state_d = sts_i.more ? mrle_pkg::ST_LOAD : mrle_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = mrle_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready_o   = 1'b0;
    out_valid_o  = 1'b0;
    cmd_o        = '0;
    case (state_q)
      mrle_pkg::ST_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
      end
      mrle_pkg::ST_LOAD: begin
        cmd_o.load = 1'b1;
      end
      mrle_pkg::ST_SEND: begin
        out_valid_o = 1'b1;
        cmd_o.next  = out_ready_i;
      end
      default: begin
      end
    endcase
  end

  `ASSERT_IMPLIES(a_one_item, clk_i, rst_ni, out_valid_o, !in_ready_o, "input taken while a result is pending")
  `ASSERT_IMPLIES(a_send_has_pkt, clk_i, rst_ni, out_valid_o, sts_i.has_pkt, "result shown with no packet planned")
  `ASSERT_NEVER(a_cmd_clash, clk_i, rst_ni, cmd_o.accept && (cmd_o.next || cmd_o.load), "accept issued with another command")

endmodule

`default_nettype wire

@@ sv/mixed_rle_pixel_encoder_unit.sv @@
// Top level of the mixed RLE pixel encoder: controller plus datapath.
// Depends on mrle_pkg, mrle_ctrl and mrle_datapath.
//
//   channel | direction | handshake                  | payload
//   --------+-----------+----------------------------+---------------------------------
//   in      | sink      | in_valid_i / in_ready_o    | pixel_value_i, end_of_line_i
//   out     | source    | out_valid_o / out_ready_i  | header, long count, 4 values, last
//
// An input beat is taken in the idle state; each result then reads a row of the four-lane
// literal buffer in the load state and is shown on the output in the send state.
// An item with no result passes through the load state and returns to idle.
// The next beat is taken only after the last result of the item has left.
// Reset is asynchronous and clears the count and run flag; the buffer is not cleared.
// A low out_ready_i holds the current result and stalls the whole block.
`default_nettype none

module mixed_rle_pixel_encoder_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [23:0] pixel_value_i,
  input  logic        end_of_line_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        has_header_o,
  output logic [7:0]  header_byte_o,
  output logic        has_long_count_o,
  output logic [15:0] long_count_o,
  output logic [2:0]  value_count_o,
  output logic [23:0] value_a_o,
  output logic [23:0] value_b_o,
  output logic [23:0] value_c_o,
  output logic [23:0] value_d_o,
  output logic        last_of_run_o
);

  mrle_pkg::dp_cmd_t cmd;
  mrle_pkg::dp_sts_t sts;

  mrle_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  mrle_datapath u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .pixel_value_i    (pixel_value_i),
    .end_of_line_i    (end_of_line_i),
    .has_header_o     (has_header_o),
    .header_byte_o    (header_byte_o),
    .has_long_count_o (has_long_count_o),
    .long_count_o     (long_count_o),
    .value_count_o    (value_count_o),
    .value_a_o        (value_a_o),
    .value_b_o        (value_b_o),
    .value_c_o        (value_c_o),
    .value_d_o        (value_d_o),
    .last_of_run_o    (last_of_run_o)
  );

endmodule

`default_nettype wire

@@ sim/tb_mixed_rle_pixel_encoder_unit.sv @@
// Self-checking testbench for mixed_rle_pixel_encoder_unit: directed pixel table, a longest
// literal under held-off output, then random scanlines of literals, runs and mixed pixels,
// scored against an in-bench packet predictor. Depends on mrle_pkg and the encoder RTL only.
`timescale 1ns / 1ps

module tb_mixed_rle_pixel_encoder_unit;

  localparam int RANDOM_ITEMS = 12;
  localparam int HOLD_CYCLES  = 200;
  localparam int DRAIN_LIMIT  = 20000;
  localparam int TAIL_CYCLES  = 20;

  typedef struct packed {
    logic        has_header;
    logic [7:0]  header_byte;
    logic        has_long_count;
    logic [15:0] long_count;
    logic [2:0]  value_count;
    logic [23:0] value_a;
    logic [23:0] value_b;
    logic [23:0] value_c;
    logic [23:0] value_d;
    logic        last_of_run;
  } rle_beat_t;

  // One directed pixel; when typed is set, the result count and first header are known.
  typedef struct packed {
    logic [23:0] pix;
    logic        eol;
    logic        typed;
    logic [5:0]  exp_n;
    logic [7:0]  exp_hdr;
  } dir_row_t;

  typedef enum logic [1:0] {
    RDY_ALWAYS,
    RDY_COIN,
    RDY_MOSTLY,
    RDY_PERIODIC
  } stall_mode_e;

  typedef enum logic [1:0] {
    SC_LITERAL,
    SC_RUN,
    SC_MIXED,
    SC_NOISE
  } scen_kind_e;

  localparam int DIR_LEN = 20;
  localparam dir_row_t DIR_ROWS [DIR_LEN] = '{
    '{24'h000000, 1'b1, 1'b1, 6'd1, 8'd0},    // lone pixel at end of line
    '{24'hFFFFFF, 1'b0, 1'b1, 6'd0, 8'd0},
    '{24'hFFFFFF, 1'b0, 1'b1, 6'd0, 8'd0},
    '{24'hFFFFFF, 1'b1, 1'b1, 6'd1, 8'd130},  // short run of three
    '{24'h000001, 1'b0, 1'b0, 6'd0, 8'd0},
    '{24'h000002, 1'b0, 1'b0, 6'd0, 8'd0},
    '{24'h000003, 1'b0, 1'b0, 6'd0, 8'd0},
    '{24'h000003, 1'b1, 1'b1, 6'd2, 8'd1},    // repeat cuts literal, pair goes as run
    '{24'hAAAAAA, 1'b0, 1'b0, 6'd0, 8'd0},
    '{24'hAAAAAA, 1'b0, 1'b0, 6'd0, 8'd0},
    '{24'h555555, 1'b1, 1'b1, 6'd2, 8'd129},  // run closed by a new pixel
    '{24'h123456, 1'b0, 1'b0, 6'd0, 8'd0},
    '{24'h654321, 1'b0, 1'b0, 6'd0, 8'd0},
    '{24'hABCDEF, 1'b0, 1'b0, 6'd0, 8'd0},
    '{24'hFEDCBA, 1'b0, 1'b0, 6'd0, 8'd0},
    '{24'h000000, 1'b0, 1'b0, 6'd0, 8'd0},
    '{24'hFFFFFF, 1'b1, 1'b1, 6'd2, 8'd5},    // literal of six spans two beats
    '{24'h800000, 1'b0, 1'b0, 6'd0, 8'd0},
    '{24'h800000, 1'b1, 1'b1, 6'd1, 8'd129},
    '{24'h7FFFFF, 1'b1, 1'b1, 6'd1, 8'd0}
  };

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        in_valid_i    = 1'b0;
  logic [23:0] pixel_value_i = '0;
  logic        end_of_line_i = 1'b0;
  logic        out_ready_i   = 1'b0;
  logic        in_ready_o;
  logic        out_valid_o;
  logic        has_header_o;
  logic [7:0]  header_byte_o;
  logic        has_long_count_o;
  logic [15:0] long_count_o;
  logic [2:0]  value_count_o;
  logic [23:0] value_a_o;
  logic [23:0] value_b_o;
  logic [23:0] value_c_o;
  logic [23:0] value_d_o;
  logic        last_of_run_o;

  mixed_rle_pixel_encoder_unit DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .pixel_value_i    (pixel_value_i),
    .end_of_line_i    (end_of_line_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .has_header_o     (has_header_o),
    .header_byte_o    (header_byte_o),
    .has_long_count_o (has_long_count_o),
    .long_count_o     (long_count_o),
    .value_count_o    (value_count_o),
    .value_a_o        (value_a_o),
    .value_b_o        (value_b_o),
    .value_c_o        (value_c_o),
    .value_d_o        (value_d_o),
    .last_of_run_o    (last_of_run_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Encoder state as the predictor sees it.
  logic [23:0]                pix_buf [mrle_pkg::MAX_LITERAL];
  logic [mrle_pkg::CNT_W-1:0] pend_cnt = '0;
  logic                       in_run   = 1'b0;

  rle_beat_t step_beats [$];
  rle_beat_t packet_beats_due [$];

  int  fail_count    = 0;
  int  items_sent    = 0;
  int  beats_seen    = 0;
  int  long_seen     = 0;
  int  full_lit_seen = 0;
  int  burst_left    = 0;
  bit  gaps_on       = 1'b1;
  bit  hold_off_req  = 1'b0;
  logic [23:0] last_pix = '0;

  task automatic compare_field(input string name, input int unsigned exp_v,
                               input int unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  task automatic emit_packet(input logic [7:0] hdr, input logic long_form,
                             input logic [15:0] run_len, input int n_vals);
    rle_beat_t   b;
    int          done;
    int          take;
    logic [23:0] v [mrle_pkg::LANES];
    done = 0;
    do begin
      take = (n_vals - done > mrle_pkg::LANES) ? mrle_pkg::LANES : n_vals - done;
      for (int j = 0; j < mrle_pkg::LANES; j++) begin
        v[j] = (j < take) ? pix_buf[mrle_pkg::LIT_IDX_W'(done + j)] : '0;
      end
      b.has_header     = (done == 0);
      b.header_byte    = (done == 0) ? hdr : '0;
      b.has_long_count = (done == 0) && long_form;
      b.long_count     = ((done == 0) && long_form) ? run_len : '0;
      b.value_count    = 3'(take);
      b.value_a        = v[0];
      b.value_b        = v[1];
      b.value_c        = v[2];
      b.value_d        = v[3];
      b.last_of_run    = 1'b0;
      step_beats.push_back(b);
      done += take;
    end while (done < n_vals);
  endtask

  task automatic emit_literal(input int n);
    if (n > 0 && n <= mrle_pkg::MAX_LITERAL) emit_packet(8'(n - 1), 1'b0, '0, n);
  endtask

  task automatic emit_run(input int n);
    logic [7:0] hdr;
    if (n < mrle_pkg::SHORT_RUN_BOUND) begin
      hdr = 8'(n) + mrle_pkg::RUN_BIAS;
      emit_packet(hdr, 1'b0, '0, 1);
    end else begin
      emit_packet(mrle_pkg::HDR_LONG, 1'b1, 16'(n), 1);
    end
  endtask

  // Advances the encoder state by one pixel and queues the beats it produces.
  task automatic predict_pixel(input logic [23:0] pix, input logic eol);
    logic same;
    step_beats.delete();
    if (pend_cnt == 0) begin
      pix_buf[0] = pix;
      pend_cnt = mrle_pkg::CNT_W'(1);
    end else if (pend_cnt == 1) begin
      in_run = (pix == pix_buf[0]);
      if (!in_run) pix_buf[1] = pix;
      pend_cnt = mrle_pkg::CNT_W'(2);
    end else begin
      if (in_run) same = (pix == pix_buf[0]);
      else same = (pend_cnt <= mrle_pkg::MAX_LITERAL) &&
                  (pix == pix_buf[mrle_pkg::LIT_IDX_W'(pend_cnt - 1'b1)]);
      if (same != in_run) begin
        if (!in_run) begin
          // The repeated pair leaves the literal and opens a run.
          emit_literal(int'(pend_cnt) - 1);
          pix_buf[0] = pix;
          pix_buf[1] = pix;
          pend_cnt = mrle_pkg::CNT_W'(2);
          in_run = 1'b1;
        end else begin
          emit_run(int'(pend_cnt));
          pix_buf[0] = pix;
          pend_cnt = mrle_pkg::CNT_W'(1);
        end
      end else begin
        if (!same && pend_cnt < mrle_pkg::MAX_LITERAL) begin
          pix_buf[pend_cnt[mrle_pkg::LIT_IDX_W-1:0]] = pix;
        end
        pend_cnt = pend_cnt + 1'b1;
        if (!in_run && pend_cnt >= mrle_pkg::MAX_LITERAL) begin
          emit_literal(mrle_pkg::MAX_LITERAL);
          pend_cnt = '0;
        end
        if (in_run && pend_cnt >= mrle_pkg::MAX_RUN) begin
          emit_packet(mrle_pkg::HDR_LONG, 1'b1, 16'(mrle_pkg::MAX_RUN), 1);
          pend_cnt = '0;
        end
      end
    end
    if (eol) begin
      if (pend_cnt != 0) begin
        if (pend_cnt == 1 || !in_run) emit_literal(int'(pend_cnt));
        else emit_run(int'(pend_cnt));
      end
      pend_cnt = '0;
      in_run = 1'b0;
    end
    for (int i = 0; i < step_beats.size(); i++) begin
      rle_beat_t b;
      b = step_beats[i];
      b.last_of_run = (i == step_beats.size() - 1);
      packet_beats_due.push_back(b);
    end
  endtask

  // Offers one pixel beat, holding it until accepted; bursts are separated by random gaps while gaps_on is set.
  task automatic offer_pixel(input logic [23:0] pix, input logic eol);
    if (gaps_on && burst_left == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      burst_left = $urandom_range(1, 12);
    end
    if (burst_left > 0) burst_left--;
    in_valid_i    <= 1'b1;
    pixel_value_i <= pix;
    end_of_line_i <= eol;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predict_pixel(pix, eol);
    last_pix = pix;
    items_sent++;
  endtask

  task automatic wait_for_results();
    in_valid_i <= 1'b0;
    burst_left = 0;
    do @(posedge clk_i); while (packet_beats_due.size() != 0);
  endtask

  // No two neighbors are equal, so the whole stretch stays a literal.
  task automatic send_literal(input int len, input logic eol_end);
    logic [23:0] v;
    v = last_pix;
    for (int k = 0; k < len; k++) begin
      v = v ^ 24'($urandom_range(1, 24'hFFFFFF));
      offer_pixel(v, eol_end && (k == len - 1));
    end
  endtask

  task automatic send_run(input logic [23:0] v, input int len, input logic eol_end);
    for (int k = 0; k < len; k++) offer_pixel(v, eol_end && (k == len - 1));
  endtask

  task automatic send_mixed(input int len);
    logic [23:0] pal [3];
    pal[0] = 24'($urandom);
    pal[1] = ($urandom_range(0, 3) == 0) ? 24'hFFFFFF : 24'($urandom);
    pal[2] = ($urandom_range(0, 3) == 0) ? 24'h000000 : 24'($urandom);
    for (int k = 0; k < len; k++) begin
      offer_pixel(pal[$urandom_range(0, 2)], (k == len - 1) && ($urandom_range(0, 3) != 0));
    end
  endtask

  task automatic send_noise(input int len);
    for (int k = 0; k < len; k++) offer_pixel(24'($urandom), $urandom_range(0, 3) == 0);
  endtask

  initial begin : ready_pattern
    stall_mode_e mode;
    int          left_in_mode;
    int          hold_left;
    mode = RDY_ALWAYS;
    left_in_mode = 0;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_left == 0 && hold_off_req) begin
        hold_left = HOLD_CYCLES;
        hold_off_req = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        if (left_in_mode == 0) begin
          mode = stall_mode_e'($urandom_range(0, 3));
          left_in_mode = $urandom_range(8, 80);
        end
        left_in_mode--;
        case (mode)
          RDY_ALWAYS: out_ready_i <= 1'b1;
          RDY_COIN:   out_ready_i <= 1'($urandom_range(0, 1));
          RDY_MOSTLY: out_ready_i <= ($urandom_range(0, 3) != 0);
          default:    out_ready_i <= ((left_in_mode % 5) >= 3);
        endcase
      end
    end
  end

  always @(posedge clk_i) begin : beat_monitor
    rle_beat_t got;
    rle_beat_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = {has_header_o, header_byte_o, has_long_count_o, long_count_o, value_count_o,
             value_a_o, value_b_o, value_c_o, value_d_o, last_of_run_o};
      beats_seen++;
      if (got.has_long_count) long_seen++;
      if (got.has_header && got.header_byte == 8'(mrle_pkg::MAX_LITERAL - 1)) full_lit_seen++;
      if (packet_beats_due.size() == 0) begin
        $error("result beat with nothing expected: header 0x%0h, %0d values",
               got.header_byte, got.value_count);
        fail_count++;
      end else begin
        want = packet_beats_due.pop_front();
        compare_field("has_header", want.has_header, got.has_header);
        compare_field("header_byte", want.header_byte, got.header_byte);
        compare_field("has_long_count", want.has_long_count, got.has_long_count);
        compare_field("long_count", want.long_count, got.long_count);
        compare_field("value_count", want.value_count, got.value_count);
        compare_field("value_a", want.value_a, got.value_a);
        compare_field("value_b", want.value_b, got.value_b);
        compare_field("value_c", want.value_c, got.value_c);
        compare_field("value_d", want.value_d, got.value_d);
        compare_field("last_of_run", want.last_of_run, got.last_of_run);
      end
    end
  end

  initial begin : stimulus
    int          rand_goal;
    int          waited;
    logic [23:0] v;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int r = 0; r < DIR_LEN; r++) begin
      offer_pixel(DIR_ROWS[r].pix, DIR_ROWS[r].eol);
      if (DIR_ROWS[r].typed) begin
        compare_field("beats for pixel", DIR_ROWS[r].exp_n, step_beats.size());
        if (step_beats.size() != 0) begin
          compare_field("first header", DIR_ROWS[r].exp_hdr, step_beats[0].header_byte);
        end
      end
    end
    wait_for_results();

    // The longest literal cut by a repeat, then end of line: the most beats per pixel.
    // The output is held off meanwhile so the encoder backs up into its input.
    send_literal(mrle_pkg::MAX_LITERAL - 1, 1'b0);
    hold_off_req = 1'b1;
    offer_pixel(last_pix, 1'b1);
    send_mixed(10);
    wait_for_results();

    rand_goal = items_sent + RANDOM_ITEMS;
    while (items_sent < rand_goal) begin
      gaps_on = ($urandom_range(0, 3) != 0);
      case (scen_kind_e'($urandom_range(0, 3)))
        SC_LITERAL: send_literal($urandom_range(1, 8), $urandom_range(0, 3) != 0);
        SC_RUN: begin
          v = ($urandom_range(0, 4) == 0) ? last_pix : 24'($urandom);
          send_run(v, $urandom_range(2, 8), $urandom_range(0, 3) != 0);
        end
        SC_MIXED: send_mixed($urandom_range(1, 8));
        default:  send_noise($urandom_range(1, 6));
      endcase
      if ($urandom_range(0, 7) == 0) wait_for_results();
    end

    in_valid_i <= 1'b0;
    waited = 0;
    while (packet_beats_due.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (packet_beats_due.size() != 0) begin
      $error("%0d expected result beats never arrived", packet_beats_due.size());
      fail_count++;
    end

    $display("Encoded %0d pixels into %0d result beats, %0d long runs, %0d full literals.",
             items_sent, beats_seen, long_seen, full_lit_seen);
    $display("Mismatches and protocol errors: %0d", fail_count);
    if (fail_count == 0) begin
      $display("tb_mixed_rle_pixel_encoder_unit: PASS");
    end else begin
      $display("tb_mixed_rle_pixel_encoder_unit: FAIL");
    end
    $finish;
  end

  // Far above the slowest legal run, even with every pixel at its most beats and stalled.
  initial begin : watchdog
    #(64'd5_000_000);
    $display("Timed out with %0d result beats outstanding", packet_beats_due.size());
    $display("tb_mixed_rle_pixel_encoder_unit: FAIL");
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+sv
sv/mrle_pkg.sv
sv/mrle_datapath.sv
sv/mrle_ctrl.sv
sv/mixed_rle_pixel_encoder_unit.sv
sim/tb_mixed_rle_pixel_encoder_unit.sv
